>>> src/ida_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ida_pkg: shared types and constants of the identifier allocator
// Command and status codes, sequencer states, and the control and status
// words passed between the sequencer and the free-identifier ring.
// ----------------------------------------------------------------------------
package ida_pkg;

  localparam int ID_BITS_DEF    = 16;
  localparam int FREE_DEPTH_DEF = 1024;

  // Fixed payload widths
  localparam int IN_ID_W   = 16;
  localparam int OUT_ID_W  = 16;
  localparam int TOTAL_W   = 17;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_EXISTS = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CRT,
    S_SCAN,
    S_OUT
  } seq_state_t;

  // Sequencer to ring
  typedef struct packed {
    logic clr;         // drop every queued identifier
    logic push;        // append the identifier at the tail
    logic pop;         // retire the oldest identifier
    logic rd_head;     // read the oldest identifier
    logic scan_start;  // park the scan pointer at the head
    logic scan_rd;     // read at the scan pointer and advance it
  } ring_ctl_t;

  // Ring to sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_end;    // every queued entry has been read by the scan
  } ring_sts_t;

endpackage
`default_nettype wire

>>> src/ida_free_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ida_free_ring: first-in first-out ring of freed identifiers
// Single-port memory with a registered read, head and tail pointers, a
// fill count, and a scan pointer that walks the queued entries in order.
// ----------------------------------------------------------------------------
module ida_free_ring import ida_pkg::*; #(
  parameter int IW         = 16,
  parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ring_ctl_t     ctl,
  input  wire logic [IW-1:0] push_id,
  output      ring_sts_t     sts,
  output      logic [IW-1:0] rd_data
);

  localparam int PTR_W  = $clog2(FREE_DEPTH);
  localparam int FILL_W = $clog2(FREE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FREE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FREE_DEPTH);

  logic [IW-1:0]     mem [FREE_DEPTH];
  logic [IW-1:0]     rd_data_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [PTR_W-1:0]  scan_r, scan_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] left_r, left_nxt;
  logic [PTR_W-1:0]  rd_addr;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    ring_next = (pos == PTR_LAST) ? '0 : pos + 1'b1;
  endfunction

  // Pointer and count updates
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    scan_nxt = scan_r;
    fill_nxt = fill_r;
    left_nxt = left_r;
    if (ctl.clr) begin
      head_nxt = '0;
      tail_nxt = '0;
      scan_nxt = '0;
      fill_nxt = '0;
      left_nxt = '0;
    end else begin
      if (ctl.push) begin
        tail_nxt = ring_next(tail_r);
        fill_nxt = fill_r + 1'b1;
      end
      if (ctl.pop) begin
        head_nxt = ring_next(head_r);
        fill_nxt = fill_r - 1'b1;
      end
      if (ctl.scan_start) begin
        scan_nxt = head_r;
        left_nxt = fill_r;
      end
      if (ctl.scan_rd) begin
        scan_nxt = ring_next(scan_r);
        left_nxt = left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      scan_r <= '0;
      fill_r <= '0;
      left_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      scan_r <= scan_nxt;
      fill_r <= fill_nxt;
      left_r <= left_nxt;
    end
  end

  assign rd_addr = ctl.rd_head ? head_r : scan_r;

  // Write at the tail, registered read at head or scan pointer
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_id;
    end
    if (ctl.rd_head || ctl.scan_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data      = rd_data_r;
  assign sts.empty    = (fill_r == '0);
  assign sts.full     = (fill_r == FILL_MAX);
  assign sts.scan_end = (left_r == '0);

endmodule
`default_nettype wire

>>> src/id_allocator_free_fifo_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id_allocator_free_fifo_unit: identifier allocator with a free-id queue
// Create hands out the oldest freed identifier, else the next fresh one
// (starting at 1); exists checks range and scans the free queue; delete
// queues a nonzero identifier; clear resets all state.
//   in_valid/in_ready carry in_cmd and in_entity_id; out_valid/out_ready
//   carry out_new_id, out_is_live, out_live_total and out_status, one word
//   per command. One command runs at a time; in_ready is high only while
//   the sequencer is idle. States from accept to result valid:
//     create from the free queue   S_EXEC reads the head, S_CRT pops, S_OUT
//     create fresh, delete, clear  S_EXEC, S_OUT
//     exists                       S_EXEC, S_OUT if out of range, else S_SCAN,
//                                  one queued entry per cycle through the
//                                  single memory port and shared comparator
//                                  to a match or the scan end, then S_OUT.
//   A command holds the block until S_OUT loads its result, then idle; a
//   stalled receiver holds the result inside until the output register
//   frees up. Synchronous reset empties the queue, next fresh id 1, count 0.
// ----------------------------------------------------------------------------
module id_allocator_free_fifo_unit import ida_pkg::*; #(
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [IN_ID_W-1:0]  in_entity_id,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [OUT_ID_W-1:0] out_new_id,
  output      logic                out_is_live,
  output      logic [TOTAL_W-1:0]  out_live_total,
  output      logic [1:0]          out_status
);

  localparam int IW      = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
  localparam int FRESH_W = ID_BITS + 1;
  localparam int DEP_W   = $clog2(FREE_DEPTH);
  localparam int CNT_W   = ((ID_BITS > DEP_W) ? ID_BITS : DEP_W) + 2;

  seq_state_t          state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [IW-1:0]       id_r, id_nxt;
  logic [FRESH_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [OUT_ID_W-1:0] res_new_r, res_new_nxt;
  logic                res_live_r, res_live_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_ID_W-1:0] out_new_r;
  logic                out_live_r;
  logic [TOTAL_W-1:0]  out_total_r;
  status_t             out_status_r;
  logic                out_load;

  ring_ctl_t           ring_ctl;
  ring_sts_t           ring_sts;
  logic [IW-1:0]       ring_rd;
  logic                id_match;
  logic [63:0]         fresh_ext;
  logic [63:0]         count_ext;

  ida_free_ring #(
    .IW         (IW),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .push_id (id_r),
    .sts     (ring_sts),
    .rd_data (ring_rd)
  );

  // Shared comparator: queue entry against the held identifier
  assign id_match  = (ring_rd == id_r);
  assign fresh_ext = 64'(fresh_r);
  assign count_ext = 64'(count_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    cmp_vld_nxt    = 1'b0;
    res_new_nxt    = res_new_r;
    res_live_nxt   = res_live_r;
    res_status_nxt = res_status_r;
    ring_ctl       = '0;
    out_load       = 1'b0;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          id_nxt         = in_entity_id[IW-1:0];
          res_new_nxt    = '0;
          res_live_nxt   = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_CREATE: begin
            if (!ring_sts.empty) begin
              ring_ctl.rd_head = 1'b1;
              state_nxt        = S_CRT;
            end else if (!fresh_r[ID_BITS]) begin
              res_new_nxt = fresh_ext[OUT_ID_W-1:0];
              fresh_nxt   = fresh_r + 1'b1;
              count_nxt   = count_r + 1'b1;
            end else begin
              res_status_nxt = ST_EXHAUSTED;
            end
          end
          CMD_EXISTS: begin
            if (id_r != '0 && FRESH_W'(id_r) < fresh_r) begin
              ring_ctl.scan_start = 1'b1;
              state_nxt           = S_SCAN;
            end
          end
          CMD_DELETE: begin
            if (id_r != '0) begin
              if (ring_sts.full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ring_ctl.push = 1'b1;
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end
          end
          CMD_CLEAR: begin
            ring_ctl.clr = 1'b1;
            fresh_nxt    = FRESH_W'(1);
            count_nxt    = '0;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_CRT: begin
        // Read data of the head entry is valid now
        res_new_nxt  = OUT_ID_W'(ring_rd);
        ring_ctl.pop = 1'b1;
        count_nxt    = count_r + 1'b1;
        state_nxt    = S_OUT;
      end
      S_SCAN: begin
        if (cmp_vld_r && id_match) begin
          res_live_nxt = 1'b0;
          state_nxt    = S_OUT;
        end else if (ring_sts.scan_end) begin
          res_live_nxt = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          ring_ctl.scan_rd = 1'b1;
          cmp_vld_nxt      = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= FRESH_W'(1);
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold command and result payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    res_new_r    <= res_new_nxt;
    res_live_r   <= res_live_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_new_r    <= res_new_r;
      out_live_r   <= res_live_r;
      out_total_r  <= count_ext[TOTAL_W-1:0];
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_id     = out_new_r;
  assign out_is_live    = out_live_r;
  assign out_live_total = out_total_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire
